FILE: rtl/tlfc_pkg.sv
// types, constants and codes shared by the line format checker modules
// no dependencies
`default_nettype none
package tlfc_pkg;

    localparam int unsigned LEN_W     = 21;
    localparam int unsigned LINE_W    = 32;
    localparam int unsigned Q_DEPTH   = 4;
    localparam int unsigned CFG_AW    = 3;

    localparam logic [LEN_W-1:0]  MAX_LINE     = 21'd1048576;
    localparam logic [LEN_W-1:0]  MIN_LINE     = 21'd2;
    localparam logic [LEN_W-1:0]  LEN_RESET    = 21'd1048576;
    localparam logic [LINE_W-1:0] LINE_MAX_CNT = 32'hFFFF_FFFF;

    localparam logic [7:0] BYTE_NL = 8'h0A;
    localparam logic [7:0] BYTE_SP = 8'h20;
    localparam logic [7:0] BYTE_HT = 8'h09;
    localparam logic [7:0] BYTE_CR = 8'h0D;
    localparam logic [7:0] BYTE_DEL = 8'h7F;

    // register index decoded from paddr[2]
    localparam logic REG_MAX_LINE_LEN = 1'b0;

    // classified input beat
    typedef struct packed {
        logic eoi;
        logic newline;
        logic ws;
        logic nonprint;
        logic nsws;
    } t_class;

    typedef struct packed {
        logic [LINE_W-1:0] line_number;
        logic [LEN_W-1:0]  position;
        logic              line_too_long;
        logic              empty_line;
        logic              no_final_newline;
        logic              leading_space;
        logic              trailing_space;
        logic              non_printable;
        logic              non_space_whitespace;
        logic              double_whitespace;
        logic              all_clean;
    } t_result;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage
`default_nettype wire

FILE: rtl/text_line_format_checker.sv
// top level of the text line format checker: config register, front end, queue, back end
// depends on tlfc_pkg, tlfc_front, tlfc_queue, tlfc_back
`default_nettype none
// Takes one text byte per input beat (tlast set marks end of text, no byte carried) and
// returns one result beat per input beat with the line number, the position within the
// line and one flag per broken format rule. Throughput is one beat per clock while the
// output is not stalled; an accepted beat goes into the queue and then into the back
// end's output register. The queue between front and back end holds QUEUE_DEPTH beats,
// so input keeps flowing while an output beat waits. max_line_length sits at address 0;
// the user must write it only while the block is idle, the block does not enforce this.
module text_line_format_checker #(
    parameter int unsigned QUEUE_DEPTH = tlfc_pkg::Q_DEPTH
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [7:0]                  s_axis_tdata,  // data_byte
    input  wire logic                        s_axis_tlast,  // end_of_input
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    // line_number[31:0], position[52:32], line_too_long 53, empty_line 54,
    // no_final_newline 55, leading_space 56, trailing_space 57, non_printable 58,
    // non_space_whitespace 59, double_whitespace 60, all_clean 61, zero 63:62
    output logic [63:0]                      m_axis_tdata,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [tlfc_pkg::CFG_AW-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    logic [tlfc_pkg::LEN_W-1:0] r_max_len;
    logic [tlfc_pkg::LEN_W-1:0] r_limit_m1, n_limit_m1;
    logic [tlfc_pkg::LEN_W-1:0] w_wr_len;
    logic                       w_cfg_wr;
    tlfc_pkg::t_class           w_class;
    tlfc_pkg::t_class           w_q_data;
    tlfc_pkg::t_q_stat          w_q_stat;
    tlfc_pkg::t_result          w_res;
    logic                       w_pop;

    assign pready = 1'b1;

    always_comb begin
        w_cfg_wr = psel && penable && pwrite && pready
                && (paddr[2] == tlfc_pkg::REG_MAX_LINE_LEN);
        w_wr_len = pwdata[tlfc_pkg::LEN_W-1:0];
        priority if (w_wr_len > tlfc_pkg::MAX_LINE) begin
            n_limit_m1 = tlfc_pkg::MAX_LINE - 1'b1;
        end else if (w_wr_len < tlfc_pkg::MIN_LINE) begin
            n_limit_m1 = tlfc_pkg::MIN_LINE - 1'b1;
        end else begin
            n_limit_m1 = w_wr_len - 1'b1;
        end
        prdata = (paddr[2] == tlfc_pkg::REG_MAX_LINE_LEN) ? 32'(r_max_len) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len  <= tlfc_pkg::LEN_RESET;
            r_limit_m1 <= tlfc_pkg::LEN_RESET - 1'b1;
        end else if (w_cfg_wr) begin
            r_max_len  <= w_wr_len;
            r_limit_m1 <= n_limit_m1;
        end
    end

    tlfc_front u_front (
        .i_byte  (s_axis_tdata),
        .i_eoi   (s_axis_tlast),
        .o_class (w_class)
    );

    assign s_axis_tready = !w_q_stat.full;

    tlfc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_axis_tvalid),
        .i_data  (w_class),
        .i_pop   (w_pop),
        .o_data  (w_q_data),
        .o_stat  (w_q_stat)
    );

    tlfc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_class     (w_q_data),
        .i_avail     (!w_q_stat.empty),
        .o_pop       (w_pop),
        .i_limit_m1  (r_limit_m1),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_result    (w_res)
    );

    assign m_axis_tdata = {2'b00,
                           w_res.all_clean,
                           w_res.double_whitespace,
                           w_res.non_space_whitespace,
                           w_res.non_printable,
                           w_res.trailing_space,
                           w_res.leading_space,
                           w_res.no_final_newline,
                           w_res.empty_line,
                           w_res.line_too_long,
                           w_res.position,
                           w_res.line_number};

`ifndef ASSERT_OFF
    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> w_q_stat.full)
        else $error("input stalled with queue space left");

    a_pop_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_q_stat.empty && (!m_axis_tvalid || m_axis_tready)) |=> m_axis_tvalid)
        else $error("queued beat not moved to output");

    a_empty_not_leading: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(w_res.empty_line && w_res.leading_space))
        else $error("empty line also flagged as leading space");
`endif

endmodule
`default_nettype wire

FILE: rtl/tlfc_front.sv
// front end: classifies each accepted byte beat for the back end
// depends on tlfc_pkg
`default_nettype none
module tlfc_front (
    input  wire logic [7:0]     i_byte,
    input  wire logic           i_eoi,
    output tlfc_pkg::t_class    o_class
);

    logic w_ws;

    always_comb begin
        w_ws = (i_byte == tlfc_pkg::BYTE_SP)
            || ((i_byte >= tlfc_pkg::BYTE_HT) && (i_byte <= tlfc_pkg::BYTE_CR));
        o_class.eoi      = i_eoi;
        o_class.newline  = !i_eoi && (i_byte == tlfc_pkg::BYTE_NL);
        o_class.ws       = w_ws;
        o_class.nonprint = (i_byte < tlfc_pkg::BYTE_SP) || (i_byte >= tlfc_pkg::BYTE_DEL);
        o_class.nsws     = w_ws && (i_byte != tlfc_pkg::BYTE_SP);
    end

endmodule
`default_nettype wire

FILE: rtl/tlfc_queue.sv
// short queue of classified beats between front and back end
// depends on tlfc_pkg
`default_nettype none
module tlfc_queue #(
    parameter int unsigned DEPTH = tlfc_pkg::Q_DEPTH
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire tlfc_pkg::t_class   i_data,
    input  wire logic               i_pop,
    output tlfc_pkg::t_class        o_data,
    output tlfc_pkg::t_q_stat       o_stat
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    tlfc_pkg::t_class r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_push, w_pop;

    always_comb begin
        o_stat.full  = (r_count == FULL_CNT);
        o_stat.empty = (r_count == '0);
        w_push = i_push && !o_stat.full;
        w_pop  = i_pop && !o_stat.empty;
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
        o_data = r_mem[r_rd_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/tlfc_back.sv
// back end: line state, rule flags and the output register
// depends on tlfc_pkg
`default_nettype none
module tlfc_back (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire tlfc_pkg::t_class             i_class,
    input  wire logic                         i_avail,
    output logic                              o_pop,
    input  wire logic [tlfc_pkg::LEN_W-1:0]   i_limit_m1,
    input  wire logic                         i_out_ready,
    output logic                              o_out_valid,
    output tlfc_pkg::t_result                 o_result
);

    logic [tlfc_pkg::LINE_W-1:0] r_line, n_line;
    logic [tlfc_pkg::LEN_W-1:0]  r_col, n_col;
    logic                        r_prev, n_prev;
    logic                        r_skip, n_skip;
    logic                        r_err, n_err;
    logic                        r_valid, n_valid;
    tlfc_pkg::t_result           r_res, n_res;
    logic                        w_close;
    logic                        w_any;

    always_comb begin
        o_pop   = i_avail && (!r_valid || i_out_ready);
        n_line  = r_line;
        n_col   = r_col;
        n_prev  = r_prev;
        n_skip  = r_skip;
        n_err   = r_err;
        w_close = 1'b0;
        n_res   = r_res;
        n_valid = r_valid && !i_out_ready;

        if (o_pop) begin
            n_valid = 1'b1;
            n_res   = '0;
            n_res.line_number = r_line;
            n_res.position    = r_col;
            priority if (i_class.eoi) begin
                if (r_skip) begin
                    w_close = 1'b1;
                end else if (r_col != '0) begin
                    n_res.no_final_newline = 1'b1;
                    n_res.trailing_space   = r_prev;
                    w_close = 1'b1;
                end
            end else if (r_skip) begin
                w_close = i_class.newline;
            end else if (i_class.newline) begin
                n_res.empty_line     = (r_col == '0);
                n_res.trailing_space = (r_col != '0) && r_prev;
                w_close = 1'b1;
            end else begin
                n_res.non_printable        = i_class.nonprint;
                n_res.non_space_whitespace = i_class.nsws;
                n_res.double_whitespace    = (r_col != '0) && i_class.ws && r_prev;
                n_res.leading_space        = (r_col == '0) && i_class.ws;
                n_prev = i_class.ws;
                if (r_col >= i_limit_m1) begin
                    n_res.line_too_long = 1'b1;
                    n_skip = 1'b1;
                end else begin
                    n_col = r_col + 1'b1;
                end
            end

            if (w_close) begin
                if (r_line != tlfc_pkg::LINE_MAX_CNT) begin
                    n_line = r_line + 1'b1;
                end
                n_col  = '0;
                n_prev = 1'b0;
                n_skip = 1'b0;
            end

            w_any = n_res.line_too_long || n_res.empty_line || n_res.no_final_newline
                 || n_res.leading_space || n_res.trailing_space || n_res.non_printable
                 || n_res.non_space_whitespace || n_res.double_whitespace;
            n_err = r_err || w_any;
            n_res.all_clean = !n_err;
        end else begin
            w_any = 1'b0;
        end

        o_out_valid = r_valid;
        o_result    = r_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line  <= tlfc_pkg::LINE_W'(1);
            r_col   <= '0;
            r_prev  <= 1'b0;
            r_skip  <= 1'b0;
            r_err   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_line  <= n_line;
            r_col   <= n_col;
            r_prev  <= n_prev;
            r_skip  <= n_skip;
            r_err   <= n_err;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

endmodule
`default_nettype wire
